// ----- rtl/core/pfs_pkg.sv -----
// pressure and flow sensor front end: shared types and constants
// no dependencies; imported by pfs_ctrl, pfs_dp and the top level
`timescale 1ns / 1ps
`default_nettype none

package pfs_pkg;

    // sample width after the absolute value (holds +32768)
    localparam int SMP_W      = 17;
    // packed result word and result flags
    localparam int OUT_DATA_W = 104;
    localparam int OUT_USER_W = 2;

    // configuration register indexes
    localparam logic [7:0] REG_SENSOR_SELECT = 8'd0;
    localparam logic [7:0] REG_PRESSURE_GAIN = 8'd1;
    localparam logic [7:0] REG_FLOW_GAIN     = 8'd2;
    localparam logic [7:0] REG_FLOW_SIGNED   = 8'd3;

    // configuration reset values
    localparam logic [31:0] PRESSURE_GAIN_RST = 32'h0001_0000;
    localparam logic [31:0] FLOW_GAIN_RST     = 32'h0001_0000;

    typedef struct packed {
        logic        sensor_select;
        logic [31:0] pressure_gain;
        logic [31:0] flow_gain;
        logic        flow_signed;
    } t_cfg;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take;
        logic upd;
        logic calc_d;
        logic mul;
        logic div_c;
        logic clamp_p;
        logic sq_init;
        logic sq_step;
        logic fmul;
        logic fclp;
        logic cal_fin;
        logic out_load;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_cal;
        logic cal_full;
        logic div_done;
        logic sq_last;
        logic out_full;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/core/pfs_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pfs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/pfs_div.sv -----
// divide by a constant through reciprocal multiplication; the result follows the busy and product registers
// no dependencies; exact for divisors up to 127 and dividends up to DIVISOR * 2**15
`timescale 1ns / 1ps
`default_nettype none

module pfs_div #(
    parameter int DVD_W   = 24,
    parameter int DIVISOR = 100
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dvd,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quo
);

    // reciprocal rounded up; its error times the dividend stays below 2**SH
    localparam int               SH    = 29;
    localparam int               RCP_W = SH + 1;
    localparam int               PRD_W = DVD_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP   =
        RCP_W'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic             r_busy;
    logic             r_done;
    logic [DVD_W-1:0] r_dvd;
    logic [PRD_W-1:0] r_prod;

    // control: start sets busy, and busy loads the product and sets done together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    // operand and product registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dvd;
        end
        if (r_busy) begin
            r_prod <= PRD_W'(r_dvd) * PRD_W'(RCP);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_prod[SH +: DVD_W];

endmodule

`default_nettype wire

// ----- rtl/core/pfs_ctrl.sv -----
// controller state machine sequencing the datapath
// depends on pfs_pkg (t_cmd, t_sts)
`timescale 1ns / 1ps
`default_nettype none

module pfs_ctrl import pfs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RD   = 5'd1;
    localparam logic [4:0] S_UPD  = 5'd2;
    localparam logic [4:0] S_CHK  = 5'd3;
    localparam logic [4:0] S_D    = 5'd4;
    localparam logic [4:0] S_MUL  = 5'd5;
    localparam logic [4:0] S_CLP  = 5'd8;
    localparam logic [4:0] S_SQI  = 5'd9;
    localparam logic [4:0] S_SQ   = 5'd10;
    localparam logic [4:0] S_FMUL = 5'd11;
    localparam logic [4:0] S_FCLP = 5'd12;
    localparam logic [4:0] S_DIVC = 5'd13;
    localparam logic [4:0] S_WC   = 5'd14;
    localparam logic [4:0] S_CFIN = 5'd15;
    localparam logic [4:0] S_OUT  = 5'd16;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD:   n_state = S_UPD;
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                if (!i_sts.is_cal) begin
                    n_state = S_D;
                end else if (i_sts.cal_full) begin
                    n_state = S_DIVC;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_D: begin
                o_cmd.calc_d = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CLP;
            end
            S_CLP: begin
                o_cmd.clamp_p = 1'b1;
                n_state       = S_SQI;
            end
            S_SQI: begin
                o_cmd.sq_init = 1'b1;
                n_state       = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                if (i_sts.sq_last) begin
                    n_state = S_FMUL;
                end
            end
            S_FMUL: begin
                o_cmd.fmul = 1'b1;
                n_state    = S_FCLP;
            end
            S_FCLP: begin
                o_cmd.fclp = 1'b1;
                n_state    = S_OUT;
            end
            S_DIVC: begin
                o_cmd.div_c = 1'b1;
                n_state     = S_WC;
            end
            S_WC: begin
                if (i_sts.div_done) begin
                    n_state = S_CFIN;
                end
            end
            S_CFIN: begin
                o_cmd.cal_fin = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/pfs_dp.sv -----
// datapath: window, offset calibration, pressure scaling, square root, flow
// depends on pfs_pkg, pfs_ram and pfs_div
`timescale 1ns / 1ps
`default_nettype none

module pfs_dp import pfs_pkg::*; #(
    parameter int WINDOW_LEN = 8,  // power of two
    parameter int CAL_COUNT  = 100
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    output t_sts                         o_sts,
    input  wire t_cfg                    i_cfg,
    input  wire logic                    i_action,
    input  wire logic [15:0]             i_sample,
    input  wire logic                    i_out_ready,
    output logic                         o_out_valid,
    output logic      [OUT_DATA_W-1:0]   o_out_data,
    output logic      [OUT_USER_W-1:0]   o_out_user
);

    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam int SUM_W  = SMP_W + $clog2(WINDOW_LEN);
    localparam int D_W    = SUM_W + 1;
    localparam int MAG_W  = SUM_W;
    localparam int PROD_W = MAG_W + 32;
    localparam int P_SH   = $clog2(WINDOW_LEN * 256);
    localparam int ACC_W  = SMP_W + $clog2(CAL_COUNT + 1);
    localparam int CNT_W  = $clog2(CAL_COUNT + 1);
    localparam logic signed [D_W-1:0] WL_S = D_W'(WINDOW_LEN);

    // item registers
    logic                     r_is_cal;
    logic signed [SMP_W-1:0]  r_smp;
    // window and calibration state
    logic [SLOT_W-1:0]        r_slot;
    logic [WINDOW_LEN-1:0]    r_valid;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [15:0]       r_off;
    logic signed [ACC_W-1:0]  r_acc;
    logic [CNT_W-1:0]         r_seen;
    logic                     r_cal_done;
    // pressure path
    logic                     r_dneg;
    logic [MAG_W-1:0]         r_dmag;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_pneg;
    logic [31:0]              r_pmag;
    logic                     r_psat;
    // square root and flow path
    logic [39:0]              r_sqv;
    logic [21:0]              r_rem;
    logic [19:0]              r_root;
    logic [4:0]               r_sqcnt;
    logic [51:0]              r_fprod;
    logic [31:0]              r_flow;
    logic                     r_fsat;
    // output register
    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;
    logic [OUT_USER_W-1:0]    r_out_user;

    logic [SMP_W-1:0]         w_rdata;
    logic signed [SMP_W-1:0]  w_old;
    logic signed [SMP_W-1:0]  w_smp_in;
    logic signed [D_W-1:0]    w_offwl;
    logic signed [D_W-1:0]    w_d;
    logic signed [D_W-1:0]    w_dneg_v;
    logic                     w_dead;
    logic [ACC_W-1:0]         w_acc_mag;
    logic                     w_div_done;
    logic [ACC_W-1:0]         w_quo;
    logic [PROD_W-1:0]        w_pq;
    logic [23:0]              w_remt;
    logic [23:0]              w_trial;
    logic [23:0]              w_rdiff;
    logic                     w_ge;
    logic [35:0]              w_fm;
    logic                     w_fneg;
    logic [16:0]              w_cq;
    logic [16:0]              w_cneg;
    logic signed [31:0]       w_sum32;
    logic [18:0]              w_ws;
    logic [31:0]              w_press;

    // sample after optional absolute value
    assign w_smp_in = (i_cfg.sensor_select && i_sample[15])
                    ? -$signed({i_sample[15], i_sample})
                    : $signed({i_sample[15], i_sample});

    pfs_ram #(
        .WIDTH (SMP_W),
        .DEPTH (WINDOW_LEN)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd && !r_is_cal),
        .i_waddr (r_slot),
        .i_wdata (r_smp),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    assign w_old = r_valid[r_slot] ? $signed(w_rdata) : '0;

    // offset-corrected difference and dead band
    assign w_offwl  = $signed({{(D_W-16){r_off[15]}}, r_off}) * WL_S;
    assign w_d      = $signed({r_sum[SUM_W-1], r_sum}) - w_offwl;
    assign w_dneg_v = -w_d;
    assign w_dead   = i_cfg.sensor_select && (w_d <= WL_S);

    // pressure scaling: division by window length times 256 is a shift
    assign w_pq = r_prod >> P_SH;

    // calibration mean magnitude by the constant count
    assign w_acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    pfs_div #(
        .DVD_W   (ACC_W),
        .DIVISOR (CAL_COUNT)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_c),
        .i_dvd   (w_acc_mag),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // square root step, two radicand bits a cycle
    assign w_remt  = {r_rem, r_sqv[39:38]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_remt >= w_trial);
    assign w_rdiff = w_remt - w_trial;

    assign w_fm   = r_fprod[51:16];
    assign w_fneg = i_cfg.flow_signed && r_pneg;

    // calibration mean magnitude, at most 32768
    assign w_cq   = w_quo[16:0];
    assign w_cneg = -w_cq;

    // window state and calibration accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_valid    <= '0;
            r_sum      <= '0;
            r_off      <= '0;
            r_acc      <= '0;
            r_seen     <= '0;
            r_cal_done <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_cal_done <= 1'b0;
            end
            if (i_cmd.upd && !r_is_cal) begin
                r_sum <= r_sum
                       + $signed({{(SUM_W-SMP_W){r_smp[SMP_W-1]}}, r_smp})
                       - $signed({{(SUM_W-SMP_W){w_old[SMP_W-1]}}, w_old});
                r_valid[r_slot] <= 1'b1;
                r_slot <= (r_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;
            end
            if (i_cmd.upd && r_is_cal) begin
                r_acc  <= r_acc + $signed({{(ACC_W-SMP_W){r_smp[SMP_W-1]}}, r_smp});
                r_seen <= r_seen + 1'b1;
            end
            if (i_cmd.cal_fin) begin
                if (r_acc[ACC_W-1]) begin
                    r_off <= $signed(w_cneg[15:0]);
                end else if (w_cq > 17'd32767) begin
                    r_off <= 16'sd32767;
                end else begin
                    r_off <= $signed(w_cq[15:0]);
                end
                r_acc      <= '0;
                r_seen     <= '0;
                r_cal_done <= 1'b1;
            end
        end
    end

    // item capture, pressure, square root and flow registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_is_cal <= i_action;
            r_smp    <= w_smp_in;
        end
        if (i_cmd.calc_d) begin
            r_dneg <= !w_dead && w_d[D_W-1];
            r_dmag <= w_dead ? '0
                    : (w_d[D_W-1] ? w_dneg_v[MAG_W-1:0] : w_d[MAG_W-1:0]);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_dmag) * PROD_W'(i_cfg.pressure_gain);
        end
        if (i_cmd.clamp_p) begin
            if (r_dneg) begin
                r_psat <= (w_pq > PROD_W'(64'h8000_0000));
                r_pmag <= (w_pq > PROD_W'(64'h8000_0000)) ? 32'h8000_0000 : w_pq[31:0];
                r_pneg <= (w_pq != '0);
            end else begin
                r_psat <= (w_pq > PROD_W'(64'h7fff_ffff));
                r_pmag <= (w_pq > PROD_W'(64'h7fff_ffff)) ? 32'h7fff_ffff : w_pq[31:0];
                r_pneg <= 1'b0;
            end
        end
        if (i_cmd.sq_init) begin
            r_sqv   <= {r_pmag, 8'h00};
            r_rem   <= '0;
            r_root  <= '0;
            r_sqcnt <= '0;
        end else if (i_cmd.sq_step) begin
            r_sqv   <= {r_sqv[37:0], 2'b00};
            r_rem   <= w_ge ? w_rdiff[21:0] : w_remt[21:0];
            r_root  <= {r_root[18:0], w_ge};
            r_sqcnt <= r_sqcnt + 1'b1;
        end
        if (i_cmd.fmul) begin
            r_fprod <= 52'(i_cfg.flow_gain) * 52'(r_root);
        end
        if (i_cmd.fclp) begin
            if (w_fneg) begin
                r_fsat <= (w_fm > 36'h0_8000_0000);
                r_flow <= (w_fm > 36'h0_8000_0000) ? 32'h8000_0000 : -w_fm[31:0];
            end else begin
                r_fsat <= (w_fm > 36'h0_7fff_ffff);
                r_flow <= (w_fm > 36'h0_7fff_ffff) ? 32'h7fff_ffff : w_fm[31:0];
            end
        end
    end

    // window sum clipped to the result field
    assign w_sum32 = $signed({{(32-SUM_W){r_sum[SUM_W-1]}}, r_sum});
    assign w_ws    = (w_sum32 > 32'sd262143)  ? 19'h3ffff
                   : (w_sum32 < -32'sd262144) ? 19'h40000
                   : w_sum32[18:0];
    assign w_press = r_pneg ? -r_pmag : r_pmag;

    // output register, holds a word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_is_cal) begin
                r_out_data <= {5'b0, r_off, 32'h0, 32'h0, w_ws};
                r_out_user <= {1'b0, r_cal_done};
            end else begin
                r_out_data <= {5'b0, r_off, r_flow, w_press, w_ws};
                r_out_user <= {r_psat | r_fsat, r_cal_done};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

    assign o_sts.is_cal   = r_is_cal;
    assign o_sts.cal_full = (r_seen == CNT_W'(CAL_COUNT));
    assign o_sts.div_done = w_div_done;
    assign o_sts.sq_last  = (r_sqcnt == 5'd19);
    assign o_sts.out_full = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/core/pressure_flow_sensor_frontend_unit.sv -----
// pressure and flow sensor front end, top level
// a measurement word runs read, update, check, difference, multiply, clamp, square root init,
// a 20-step square root, flow multiply, flow clamp and result load; a calibration word goes
// from check to result load, first through the divider when it closes a calibration run
// one word at a time, the next can be taken from the cycle after its result loads; a held result stalls it
// reset: synchronous active low; clears window, running sum, offset, calibration, configuration and output valid
`timescale 1ns / 1ps
`default_nettype none

module pressure_flow_sensor_frontend_unit import pfs_pkg::*; #(
    parameter int WINDOW_LEN = 8,  // power of two
    parameter int CAL_COUNT  = 100
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [15:0]           i_s_tdata,  // [15:0] sample
    input  wire logic                  i_s_tuser,  // [0] action
    // result stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // [18:0] window_sum, [50:19] pressure_q8, [82:51] flow_q8, [98:83] offset_now, zero fill
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    output logic [OUT_USER_W-1:0]      o_m_tuser,  // [0] cal_done, [1] saturated
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [7:0]            i_cfg_index,
    input  wire logic [31:0]           i_cfg_data
);

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    // configuration registers, unknown indexes ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_select <= 1'b0;
            r_cfg.pressure_gain <= PRESSURE_GAIN_RST;
            r_cfg.flow_gain     <= FLOW_GAIN_RST;
            r_cfg.flow_signed   <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SENSOR_SELECT: r_cfg.sensor_select <= i_cfg_data[0];
                REG_PRESSURE_GAIN: r_cfg.pressure_gain <= i_cfg_data;
                REG_FLOW_GAIN:     r_cfg.flow_gain     <= i_cfg_data;
                REG_FLOW_SIGNED:   r_cfg.flow_signed   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    pfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pfs_dp #(
        .WINDOW_LEN (WINDOW_LEN),
        .CAL_COUNT  (CAL_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg       (r_cfg),
        .i_action    (i_s_tuser),
        .i_sample    (i_s_tdata),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata),
        .o_out_user  (o_m_tuser)
    );

`ifndef SYNTHESIS
    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !w_sts.out_full)
        else $error("result loaded while output register full");

    // a loaded result is offered on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_m_tvalid)
        else $error("loaded result not offered");

    // input ready drops once a word is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.take |=> !o_s_tready)
        else $error("input ready while word in progress");

    // the divider is only started from an idle point
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_c |=> !w_sts.div_done)
        else $error("divider done straight after start");
`endif

endmodule

`default_nettype wire
